### rtl/core/bpr_pkg.sv
// ----------------------------------------------------------------------------
// bpr_pkg
// Shared types, widths and constants of the brick pose point rotator.
// ----------------------------------------------------------------------------
`default_nettype none

package bpr_pkg;

  // Field widths
  localparam int Q_W       = 24;  // Q8.16 coordinate
  localparam int ANG_W     = 16;  // angle in 1/65536 turn
  localparam int OFS_W     = 21;  // offset register, Q.16 unsigned
  localparam int CS_W      = 32;  // CORDIC x/y, Q2.30
  localparam int Z_W       = 24;  // residual angle in 1/2^24 turn
  localparam int CFG_IDX_W = 2;

  // Parameter defaults and fixed counts
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_LEN          = 24;
  localparam int NUM_STUDS         = 8;
  localparam int STUD_W            = $clog2(NUM_STUDS);

  // CORDIC gain 0.6072529 in Q2.30
  localparam logic signed [CS_W-1:0] CORDIC_K = 32'sd652032874;

  // Offset register reset values
  localparam logic [OFS_W-1:0] INNER_RESET = 21'd32768;
  localparam logic [OFS_W-1:0] OUTER_RESET = 21'd98304;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INNER = 2'd0,
    CFG_OUTER = 2'd1
  } bpr_cfg_idx_t;

  // atan(2^-i) in 1/2^24 turn
  localparam logic signed [Z_W-1:0] ATAN_TURN [ATAN_LEN] = '{
    24'sd2097152, 24'sd1238021, 24'sd654136, 24'sd332050,
    24'sd166669,  24'sd83416,   24'sd41718,  24'sd20860,
    24'sd10430,   24'sd5215,    24'sd2608,   24'sd1304,
    24'sd652,     24'sd326,     24'sd163,    24'sd81,
    24'sd41,      24'sd20,      24'sd10,     24'sd5,
    24'sd3,       24'sd1,       24'sd1,      24'sd0
  };

  // Pose fields that ride along the rotation chain
  typedef struct packed {
    logic                  op;
    logic signed [Q_W-1:0] cx;
    logic signed [Q_W-1:0] cy;
    logic signed [Q_W-1:0] px;
    logic signed [Q_W-1:0] py;
    logic [1:0]            quad;
  } bpr_pose_t;

  // Contents of one rotation cell
  typedef struct packed {
    logic signed [CS_W-1:0] x;
    logic signed [CS_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    bpr_pose_t              pose;
  } bpr_cell_t;

endpackage

`default_nettype wire

### rtl/core/bpr_cordic_cell.sv
// ----------------------------------------------------------------------------
// bpr_cordic_cell
// One CORDIC micro-rotation with a fixed shift, registered, in the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module bpr_cordic_cell
  import bpr_pkg::*;
#(
  parameter int SHIFT = 0
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      adv,
  input  wire logic      in_valid,
  input  wire bpr_cell_t in_cell,
  output logic           out_valid,
  output bpr_cell_t      out_cell
);

  logic      valid_r;
  bpr_cell_t cell_r;
  bpr_cell_t cell_nxt;
  logic signed [CS_W-1:0] xs;
  logic signed [CS_W-1:0] ys;

  // Rotate toward zero residual; floor shifts
  always_comb begin
    xs       = in_cell.x >>> SHIFT;
    ys       = in_cell.y >>> SHIFT;
    cell_nxt = in_cell;
    if (!in_cell.z[Z_W-1]) begin
      cell_nxt.x = in_cell.x - ys;
      cell_nxt.y = in_cell.y + xs;
      cell_nxt.z = in_cell.z - ATAN_TURN[SHIFT];
    end else begin
      cell_nxt.x = in_cell.x + ys;
      cell_nxt.y = in_cell.y - xs;
      cell_nxt.z = in_cell.z + ATAN_TURN[SHIFT];
    end
  end

  // Advance valid with the chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  // Advance data with the chain
  always_ff @(posedge clk) begin
    if (adv) begin
      cell_r <= cell_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_cell  = cell_r;

endmodule

`default_nettype wire

### rtl/core/bpr_stud_emitter.sv
// ----------------------------------------------------------------------------
// bpr_stud_emitter
// Applies the quarter turn, sequences the offsets and rotates one point per
// cycle unless stalled, via a product and a rounding/saturating output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bpr_stud_emitter
  import bpr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             tail_valid,
  input  wire bpr_cell_t        tail_cell,
  output logic                  tail_take,
  input  wire logic [OFS_W-1:0] inner_ofs,
  input  wire logic [OFS_W-1:0] outer_ofs,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic signed [Q_W-1:0] out_x,
  output logic signed [Q_W-1:0] out_y,
  output logic [STUD_W-1:0]     out_stud_index,
  output logic                  out_last
);

  localparam int D_W  = Q_W + 1;       // exact point minus center
  localparam int P_W  = D_W + CS_W;    // product width
  localparam int S_W  = P_W + 1;       // sum of two products
  localparam int R_W  = S_W - 30;      // after the Q2.30 shift
  localparam int T_W  = R_W + 1;       // plus center
  localparam logic [STUD_W-1:0] LAST_K = STUD_W'(NUM_STUDS - 1);
  localparam logic signed [S_W-1:0] HALF = S_W'(64'sd536870912);
  localparam logic signed [T_W-1:0] SAT_MAX = T_W'(64'sd8388607);
  localparam logic signed [T_W-1:0] SAT_MIN = T_W'(-64'sd8388608);

  // Sequencer registers
  logic                   busy_r, busy_nxt;
  logic [STUD_W-1:0]      k_r, k_nxt;
  logic                   op_r;
  logic signed [Q_W-1:0]  cx_r, cy_r;
  logic signed [CS_W-1:0] cs_r, sn_r;
  logic signed [D_W-1:0]  ux_r, uy_r;

  // Product stage registers
  logic                   pv_r;
  logic                   pop_r;
  logic signed [P_W-1:0]  p1_r, p2_r, p3_r, p4_r;
  logic signed [Q_W-1:0]  pcx_r, pcy_r;
  logic [STUD_W-1:0]      pk_r;
  logic                   plast_r;

  // Output stage registers
  logic                   ov_r;
  logic signed [Q_W-1:0]  ox_r, oy_r;
  logic [STUD_W-1:0]      ok_r;
  logic                   olast_r;

  logic adv;
  logic issue;
  logic issue_last;
  logic load;
  logic signed [CS_W-1:0] cs_nxt, sn_nxt;
  logic signed [D_W-1:0]  hmag, ymag, ax, ay;
  logic signed [S_W-1:0]  sum_x, sum_y;
  logic signed [S_W-1:0]  rnd_x, rnd_y;
  logic signed [T_W-1:0]  tot_x, tot_y;
  logic signed [Q_W-1:0]  sat_x, sat_y;

  // Handshake and sequencing control
  always_comb begin
    adv        = !ov_r || !out_stall;
    issue      = busy_r && adv;
    issue_last = issue && (op_r || (k_r == LAST_K));
    load       = tail_valid && adv && (!busy_r || issue_last);
    busy_nxt   = busy_r;
    k_nxt      = k_r;
    if (load) begin
      busy_nxt = 1'b1;
      k_nxt    = '0;
    end else if (issue_last) begin
      busy_nxt = 1'b0;
    end else if (issue) begin
      k_nxt = k_r + STUD_W'(1);
    end
  end

  assign tail_take = load;

  // Apply the quarter turn exactly
  always_comb begin
    case (tail_cell.pose.quad)
      2'd0: begin
        cs_nxt = tail_cell.x;
        sn_nxt = tail_cell.y;
      end
      2'd1: begin
        cs_nxt = -tail_cell.y;
        sn_nxt = tail_cell.x;
      end
      2'd2: begin
        cs_nxt = -tail_cell.x;
        sn_nxt = -tail_cell.y;
      end
      default: begin
        cs_nxt = tail_cell.y;
        sn_nxt = -tail_cell.x;
      end
    endcase
  end

  // Hold sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      k_r    <= '0;
    end else begin
      busy_r <= busy_nxt;
      k_r    <= k_nxt;
    end
  end

  // Capture the transaction from the chain tail
  always_ff @(posedge clk) begin
    if (load) begin
      op_r <= tail_cell.pose.op;
      cx_r <= tail_cell.pose.cx;
      cy_r <= tail_cell.pose.cy;
      cs_r <= cs_nxt;
      sn_r <= sn_nxt;
      ux_r <= D_W'(tail_cell.pose.px) - D_W'(tail_cell.pose.cx);
      uy_r <= D_W'(tail_cell.pose.py) - D_W'(tail_cell.pose.cy);
    end
  end

  // Select offsets: outer row on the upper half, signs from the corner
  always_comb begin
    hmag = D_W'({1'b0, inner_ofs});
    ymag = k_r[STUD_W-1] ? D_W'({1'b0, outer_ofs}) : hmag;
    if (op_r) begin
      ax = ux_r;
      ay = uy_r;
    end else begin
      ax = (k_r[0] == k_r[1]) ? -hmag : hmag;
      ay = k_r[1] ? -ymag : ymag;
    end
  end

  // Product stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (adv) begin
      pv_r <= issue;
    end
  end

  // Form the four products
  always_ff @(posedge clk) begin
    if (adv) begin
      pop_r   <= op_r;
      p1_r    <= P_W'(ax) * P_W'(cs_r);
      p2_r    <= P_W'(ay) * P_W'(sn_r);
      p3_r    <= P_W'(ax) * P_W'(sn_r);
      p4_r    <= P_W'(ay) * P_W'(cs_r);
      pcx_r   <= op_r ? '0 : cx_r;
      pcy_r   <= op_r ? '0 : cy_r;
      pk_r    <= op_r ? '0 : k_r;
      plast_r <= op_r || (k_r == LAST_K);
    end
  end

  // Sum, round half up, add center and saturate
  always_comb begin
    if (pop_r) begin
      sum_x = S_W'(p1_r) + S_W'(p2_r);
      sum_y = S_W'(p4_r) - S_W'(p3_r);
    end else begin
      sum_x = S_W'(p1_r) - S_W'(p2_r);
      sum_y = S_W'(p3_r) + S_W'(p4_r);
    end
    rnd_x = (sum_x + HALF) >>> 30;
    rnd_y = (sum_y + HALF) >>> 30;
    tot_x = T_W'($signed(rnd_x[R_W-1:0])) + T_W'(pcx_r);
    tot_y = T_W'($signed(rnd_y[R_W-1:0])) + T_W'(pcy_r);
    if (tot_x > SAT_MAX) begin
      sat_x = SAT_MAX[Q_W-1:0];
    end else if (tot_x < SAT_MIN) begin
      sat_x = SAT_MIN[Q_W-1:0];
    end else begin
      sat_x = tot_x[Q_W-1:0];
    end
    if (tot_y > SAT_MAX) begin
      sat_y = SAT_MAX[Q_W-1:0];
    end else if (tot_y < SAT_MIN) begin
      sat_y = SAT_MIN[Q_W-1:0];
    end else begin
      sat_y = tot_y[Q_W-1:0];
    end
  end

  // Output stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= pv_r;
    end
  end

  // Hold the result while stalled
  always_ff @(posedge clk) begin
    if (adv) begin
      ox_r    <= sat_x;
      oy_r    <= sat_y;
      ok_r    <= pk_r;
      olast_r <= plast_r;
    end
  end

  assign out_valid      = ov_r;
  assign out_x          = ox_r;
  assign out_y          = oy_r;
  assign out_stud_index = ok_r;
  assign out_last       = olast_r;

endmodule

`default_nettype wire

### rtl/core/brick_pose_point_rotator.sv
// ----------------------------------------------------------------------------
// brick_pose_point_rotator
// Rotates brick stud offsets into world coordinates, or world points into
// the brick frame, using a pipelined CORDIC for sin and cos.
// ----------------------------------------------------------------------------
// A transaction enters a row of CORDIC_STAGES rotation cells and then an
// emitter that produces one result per cycle while not stalled. Op 1 gives
// one result, so such transactions flow at one per cycle; op 0 gives eight
// results, so the emitter takes the next one only as it issues the last.
// The first result passes the rotation cells and the emitter's capture,
// product and output registers. The chain holds while its tail waits for
// the emitter, which holds while the result is stalled. Offsets are read
// while results are produced, so write them only when the block is idle.
`default_nettype none

module brick_pose_point_rotator
  import bpr_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Input transaction
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_op,
  input  wire logic signed [Q_W-1:0] in_center_x,
  input  wire logic signed [Q_W-1:0] in_center_y,
  input  wire logic [ANG_W-1:0]     in_turn_angle,
  input  wire logic signed [Q_W-1:0] in_point_x,
  input  wire logic signed [Q_W-1:0] in_point_y,
  // Result transaction
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic signed [Q_W-1:0]     out_x,
  output logic signed [Q_W-1:0]     out_y,
  output logic [STUD_W-1:0]         out_stud_index,
  output logic                      out_last,
  // Configuration
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [OFS_W-1:0]     cfg_wdata
);

  logic [OFS_W-1:0] inner_r;
  logic [OFS_W-1:0] outer_r;

  logic      chain_valid [CORDIC_STAGES+1];
  bpr_cell_t chain_cell  [CORDIC_STAGES+1];
  bpr_cell_t head_cell;
  logic      adv;
  logic      tail_take;
  logic [1:0]       quad;
  logic [ANG_W-1:0] biased;
  logic [ANG_W-1:0] resid;

  // Write offset registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_r <= INNER_RESET;
      outer_r <= OUTER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INNER: inner_r <= cfg_wdata;
        CFG_OUTER: outer_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Split the angle into a quarter turn and a signed residual
  always_comb begin
    biased = in_turn_angle + ANG_W'(8192);
    quad   = biased[ANG_W-1:ANG_W-2];
    resid  = in_turn_angle - {quad, {(ANG_W-2){1'b0}}};
  end

  // Build the head of the chain
  always_comb begin
    head_cell.x         = CORDIC_K;
    head_cell.y         = '0;
    head_cell.z         = {resid, 8'd0};
    head_cell.pose.op   = in_op;
    head_cell.pose.cx   = in_center_x;
    head_cell.pose.cy   = in_center_y;
    head_cell.pose.px   = in_point_x;
    head_cell.pose.py   = in_point_y;
    head_cell.pose.quad = quad;
  end

  // Feed the head of the chain
  assign chain_valid[0] = in_valid;
  assign chain_cell[0]  = head_cell;

  // Advance the chain when the tail is empty or taken
  assign adv      = !chain_valid[CORDIC_STAGES] || tail_take;
  assign in_stall = !adv;

  // Rotation cells
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    bpr_cordic_cell #(
      .SHIFT (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .in_valid  (chain_valid[i]),
      .in_cell   (chain_cell[i]),
      .out_valid (chain_valid[i+1]),
      .out_cell  (chain_cell[i+1])
    );
  end

  // Result sequencing and rotation
  bpr_stud_emitter u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .tail_valid     (chain_valid[CORDIC_STAGES]),
    .tail_cell      (chain_cell[CORDIC_STAGES]),
    .tail_take      (tail_take),
    .inner_ofs      (inner_r),
    .outer_ofs      (outer_r),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_x          (out_x),
    .out_y          (out_y),
    .out_stud_index (out_stud_index),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire

### tb/brick_pose_point_rotator_tb.sv
// ----------------------------------------------------------------------------
// brick_pose_point_rotator_tb
// Checks stud placement and world-to-brick point transforms against a
// behavioral CORDIC rotation, under random idling on both sides, a long
// result hold-off and changing stud offsets.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module brick_pose_point_rotator_tb;
  import bpr_pkg::*;

  localparam int ROT_STAGES   = 16;
  localparam int SETTLE_WAIT  = 2 * (ROT_STAGES + 3) + 8;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int PHASE_ITEMS  = 80;
  localparam int PHASE_COUNT  = 4;
  localparam longint Q_HI     = 8388607;
  localparam longint Q_LO     = -8388608;
  localparam longint ROT_GAIN = 652032874;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_3 = 2'd3;
  localparam logic [OFS_W-1:0]     OFS_ALL_ONES = 21'h1FFFFF;

  // atan(2^-i) in 1/2^24 turn
  localparam longint ATAN_STEP [24] = '{
    2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
    10430, 5215, 2608, 1304, 652, 326, 163, 81,
    41, 20, 10, 5, 3, 1, 1, 0
  };
  localparam int STUD_SX [8] = '{-1, 1, 1, -1, -1, 1, 1, -1};
  localparam int STUD_SY [8] = '{1, 1, -1, -1, 1, 1, -1, -1};

  typedef enum logic {
    OP_STUDS    = 1'b0,
    OP_TO_BRICK = 1'b1
  } pose_op_t;

  typedef struct {
    pose_op_t              op;
    logic signed [Q_W-1:0] cx;
    logic signed [Q_W-1:0] cy;
    logic [ANG_W-1:0]      ang;
    logic signed [Q_W-1:0] px;
    logic signed [Q_W-1:0] py;
  } brick_pose_t;

  typedef struct {
    logic signed [Q_W-1:0] x;
    logic signed [Q_W-1:0] y;
    logic [STUD_W-1:0]     idx;
    logic                  last;
  } stud_coord_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                  in_valid;
  logic                  in_stall;
  logic                  in_op;
  logic signed [Q_W-1:0] in_center_x;
  logic signed [Q_W-1:0] in_center_y;
  logic [ANG_W-1:0]      in_turn_angle;
  logic signed [Q_W-1:0] in_point_x;
  logic signed [Q_W-1:0] in_point_y;
  logic                  out_valid;
  logic                  out_stall;
  logic signed [Q_W-1:0] out_x;
  logic signed [Q_W-1:0] out_y;
  logic [STUD_W-1:0]     out_stud_index;
  logic                  out_last;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [OFS_W-1:0]      cfg_wdata;

  // Offsets as the block should hold them
  logic [OFS_W-1:0] inner_ofs;
  logic [OFS_W-1:0] outer_ofs;

  stud_coord_t pending_coords [$];
  stud_coord_t head_coord;
  int          fail_count  = 0;
  int          cycle_count = 0;
  bit          idling_on   = 1'b1;
  int          hold_requests = 0;
  int          holds_served  = 0;

  brick_pose_point_rotator #(.CORDIC_STAGES(ROT_STAGES)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_center_x    (in_center_x),
    .in_center_y    (in_center_y),
    .in_turn_angle  (in_turn_angle),
    .in_point_x     (in_point_x),
    .in_point_y     (in_point_y),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_x          (out_x),
    .out_y          (out_y),
    .out_stud_index (out_stud_index),
    .out_last       (out_last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // cos and sin of the angle in Q2.30: CORDIC on the residual, quadrant exact
  function automatic void turn_sincos(input logic [ANG_W-1:0] ang,
                                      output longint cs, output longint sn);
    longint a, r, x, y, z, xs, ys;
    int     q;
    a = longint'(ang);
    q = int'(((a + 8192) >>> 14) & 3);
    r = ((a - longint'(q) * 16384 + 32768) & 64'hFFFF) - 32768;
    x = ROT_GAIN;
    y = 0;
    z = r * 256;
    for (int i = 0; i < ROT_STAGES && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_STEP[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_STEP[i];
      end
    end
    case (q)
      0: begin cs = x;  sn = y;  end
      1: begin cs = -y; sn = x;  end
      2: begin cs = -x; sn = -y; end
      default: begin cs = y; sn = -x; end
    endcase
  endfunction

  // Round half up from Q.46 to Q.16
  function automatic longint round_q30(input longint p);
    return (p + 64'sd536870912) >>> 30;
  endfunction

  function automatic logic signed [Q_W-1:0] clamp_q24(input longint v);
    if (v > Q_HI) return Q_W'(Q_HI);
    if (v < Q_LO) return Q_W'(Q_LO);
    return Q_W'(v);
  endfunction

  // Queue the coordinates one pose should produce
  function automatic void queue_pose_coords(input brick_pose_t p);
    longint      cs, sn, cx, cy, h, o, dx, dy;
    stud_coord_t c;
    turn_sincos(p.ang, cs, sn);
    cx = longint'(p.cx);
    cy = longint'(p.cy);
    if (p.op == OP_STUDS) begin
      h = longint'(inner_ofs);
      o = longint'(outer_ofs);
      for (int k = 0; k < NUM_STUDS; k++) begin
        dx = STUD_SX[k] * h;
        dy = STUD_SY[k] * (k < 4 ? h : o);
        c.x    = clamp_q24(cx + round_q30(dx * cs - dy * sn));
        c.y    = clamp_q24(cy + round_q30(dx * sn + dy * cs));
        c.idx  = STUD_W'(k);
        c.last = (k == NUM_STUDS - 1);
        pending_coords.push_back(c);
      end
    end else begin
      dx = longint'(p.px) - cx;
      dy = longint'(p.py) - cy;
      c.x    = clamp_q24(round_q30(dx * cs + dy * sn));
      c.y    = clamp_q24(round_q30(dy * cs - dx * sn));
      c.idx  = '0;
      c.last = 1'b1;
      pending_coords.push_back(c);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: stall at random or on request, and check each transaction
  // ---------------------------------------------------------------------------
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_served) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_served++;
        out_stall <= 1'b0;
      end else if (idling_on) begin
        out_stall <= ($urandom_range(0, 99) < 32);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_coords.size() == 0) begin
        $error("unexpected result x=%0d y=%0d stud_index=%0d",
               out_x, out_y, out_stud_index);
        fail_count++;
      end else begin
        head_coord = pending_coords.pop_front();
        if (out_x !== head_coord.x) begin
          $error("out_x expected %0d actual %0d", head_coord.x, out_x);
          fail_count++;
        end
        if (out_y !== head_coord.y) begin
          $error("out_y expected %0d actual %0d", head_coord.y, out_y);
          fail_count++;
        end
        if (out_stud_index !== head_coord.idx) begin
          $error("stud_index expected %0d actual %0d", head_coord.idx, out_stud_index);
          fail_count++;
        end
        if (out_last !== head_coord.last) begin
          $error("last expected %0d actual %0d", head_coord.last, out_last);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one pose; entered and left at a falling edge, valid left high
  task automatic send_pose(input brick_pose_t p);
    while (idling_on && $urandom_range(0, 99) < 32) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= p.op;
    in_center_x   <= p.cx;
    in_center_y   <= p.cy;
    in_turn_angle <= p.ang;
    in_point_x    <= p.px;
    in_point_y    <= p.py;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    queue_pose_coords(p);
    @(negedge clk);
  endtask

  task automatic send_fields(input pose_op_t op, input longint cx, input longint cy,
                             input int ang, input longint px, input longint py);
    brick_pose_t p;
    p.op  = op;
    p.cx  = Q_W'(cx);
    p.cy  = Q_W'(cy);
    p.ang = ANG_W'(ang);
    p.px  = Q_W'(px);
    p.py  = Q_W'(py);
    send_pose(p);
  endtask

  // Drop valid and wait until the block has drained
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_coords.size() != 0) @(negedge clk);
    repeat (SETTLE_WAIT) @(negedge clk);
  endtask

  // Switch idling on both sides at a rising edge, away from the stall driver
  task automatic set_idling(input bit on);
    in_valid <= 1'b0;
    @(posedge clk);
    idling_on = on;
    @(negedge clk);
  endtask

  // Write one register; the block must be idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [OFS_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      CFG_INNER: inner_ofs = value;
      CFG_OUTER: outer_ofs = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Random content
  // ---------------------------------------------------------------------------
  function automatic logic signed [Q_W-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return Q_W'(Q_HI);
      1: return Q_W'(Q_LO);
      2, 3: return Q_W'($urandom);
      default: return Q_W'(int'($urandom_range(0, 2097152)) - 1048576);
    endcase
  endfunction

  function automatic logic [ANG_W-1:0] pick_angle();
    if ($urandom_range(0, 4) == 0)
      return ANG_W'(8192 * $urandom_range(0, 7) + $urandom_range(0, 2) - 1);
    return ANG_W'($urandom);
  endfunction

  function automatic logic [OFS_W-1:0] pick_offset();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return OFS_ALL_ONES;
      2: return OFS_W'(1048576);
      3: return OFS_W'($urandom);
      default: return OFS_W'($urandom_range(0, 262144));
    endcase
  endfunction

  function automatic brick_pose_t pick_pose();
    brick_pose_t p;
    p.op  = $urandom_range(0, 1) ? OP_TO_BRICK : OP_STUDS;
    p.cx  = pick_coord();
    p.cy  = pick_coord();
    p.ang = pick_angle();
    p.px  = pick_coord();
    p.py  = pick_coord();
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Quadrant edges, saturation and far points with reset offsets
  task automatic test_angles_and_saturation();
    send_fields(OP_STUDS, 0, 0, 0, 0, 0);
    send_fields(OP_STUDS, 65536, -65536, 16384, 0, 0);
    send_fields(OP_STUDS, 0, 0, 32768, 0, 0);
    send_fields(OP_STUDS, -131072, 0, 49152, 0, 0);
    send_fields(OP_STUDS, 12345, 67890, 8191, 0, 0);
    send_fields(OP_STUDS, 0, 0, 8192, 0, 0);
    send_fields(OP_STUDS, 0, 0, 65535, 0, 0);
    send_fields(OP_STUDS, Q_HI, Q_HI, 8192, 0, 0);
    send_fields(OP_STUDS, Q_LO, Q_LO, 40960, 0, 0);
    send_fields(OP_TO_BRICK, 300000, -200000, 0, 300000, -200000);
    send_fields(OP_TO_BRICK, Q_LO, Q_LO, 0, Q_HI, Q_HI);
    send_fields(OP_TO_BRICK, Q_HI, Q_LO, 32768, Q_LO, Q_HI);
    send_fields(OP_TO_BRICK, 65536, 131072, 24576, -98304, 40000);
    settle();
  endtask

  // Offsets at both ends of the register, and writes to unused indexes
  task automatic test_offset_extremes();
    write_reg(CFG_INNER, OFS_ALL_ONES);
    write_reg(CFG_OUTER, '0);
    send_fields(OP_STUDS, 0, 0, 0, 0, 0);
    send_fields(OP_STUDS, Q_HI, 0, 57344, 0, 0);
    settle();
    write_reg(CFG_INNER, '0);
    write_reg(CFG_OUTER, OFS_ALL_ONES);
    send_fields(OP_STUDS, 0, 0, 8192, 0, 0);
    send_fields(OP_STUDS, Q_LO, 0, 24576, 0, 0);
    settle();
    write_reg(CFG_UNUSED_2, 21'h155555);
    write_reg(CFG_UNUSED_3, 21'h0AAAAA);
    send_fields(OP_STUDS, 1000, -1000, 4096, 0, 0);
    settle();
    write_reg(CFG_INNER, INNER_RESET);
    write_reg(CFG_OUTER, OUTER_RESET);
  endtask

  // Random poses in phases with fresh offsets; one phase runs without idling
  task automatic test_random_traffic();
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      write_reg(CFG_INNER, pick_offset());
      write_reg(CFG_OUTER, pick_offset());
      if (ph == 2) set_idling(1'b0);
      for (int n = 0; n < PHASE_ITEMS; n++) send_pose(pick_pose());
      if (ph == 2) set_idling(1'b1);
      settle();
    end
  endtask

  // Hold results for a long stretch while poses keep arriving
  task automatic test_result_holdoff();
    set_idling(1'b0);
    in_valid <= 1'b0;
    @(posedge clk);
    hold_requests++;
    @(negedge clk);
    for (int n = 0; n < 24; n++) send_pose(pick_pose());
    set_idling(1'b1);
    settle();
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_op         = OP_STUDS;
    in_center_x   = '0;
    in_center_y   = '0;
    in_turn_angle = '0;
    in_point_x    = '0;
    in_point_y    = '0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_INNER;
    cfg_wdata     = '0;
    inner_ofs     = INNER_RESET;
    outer_ofs     = OUTER_RESET;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_angles_and_saturation();
    test_offset_extremes();
    test_random_traffic();
    test_result_holdoff();

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
